// ===== rtl/core/key_hold_event_tracker_defines.svh =====
// Assertion macros for the checker file of the key hold event tracker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef KEY_HOLD_EVENT_TRACKER_DEFINES_SVH
`define KEY_HOLD_EVENT_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KHET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KHET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/khet_pkg.sv =====
`default_nettype none

package khet_pkg;

    localparam int NUM_KEYS   = 55;
    localparam int KEY_W      = 6;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [KEY_W-1:0] t_key;

    // Request kinds.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_BUMP  = 2'd2;

    // Auto-repeat modes.
    localparam logic [1:0] RPT_NORMAL = 2'd1;
    localparam logic [1:0] RPT_SHORT  = 2'd2;

    localparam t_count COUNT_MAX   = 8'd255;
    localparam t_count COUNT_ONE   = 8'd1;
    localparam t_count NORMAL_FIRE = 8'd8;
    localparam t_count NORMAL_BACK = 8'd6;
    localparam t_count SHORT_FIRE  = 8'd6;
    localparam t_count SHORT_BACK  = 8'd4;

    // Tap-or-hold codes.
    localparam logic [1:0] TOH_NONE = 2'd0;
    localparam logic [1:0] TOH_TAP  = 2'd1;
    localparam logic [1:0] TOH_HOLD = 2'd2;

    // Direction codes, laid out like a numeric keypad.
    localparam logic [3:0] DIR_NONE  = 4'd0;
    localparam logic [3:0] DIR_DL    = 4'd1;
    localparam logic [3:0] DIR_DOWN  = 4'd2;
    localparam logic [3:0] DIR_DR    = 4'd3;
    localparam logic [3:0] DIR_LEFT  = 4'd4;
    localparam logic [3:0] DIR_RIGHT = 4'd6;
    localparam logic [3:0] DIR_UL    = 4'd7;
    localparam logic [3:0] DIR_UP    = 4'd8;
    localparam logic [3:0] DIR_UR    = 4'd9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_UP_KEY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_KEY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_KEY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_KEY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 3'd5;

    localparam t_key   RST_UP_KEY     = 6'd3;
    localparam t_key   RST_DOWN_KEY   = 6'd12;
    localparam t_key   RST_LEFT_KEY   = 6'd13;
    localparam t_key   RST_RIGHT_KEY  = 6'd2;
    localparam t_count RST_SHORT_HOLD = 8'd7;
    localparam t_count RST_LONG_HOLD  = 8'd14;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [NUM_KEYS-1:0] key_bits;
        t_key                key_index;
        logic [1:0]          repeat_mode;
    } t_req;

    typedef struct packed {
        t_count     hold_count;
        logic       first_press;
        logic       released;
        logic       short_mark;
        logic       long_mark;
        logic       repeat_fire;
        logic [1:0] tap_or_hold;
        logic [3:0] dir_four;
        logic [3:0] dir_eight;
    } t_rsp;

    // Per-key part of a result, produced by the counter bank.
    typedef struct packed {
        t_count     hold_count;
        logic       first_press;
        logic       released;
        logic       short_mark;
        logic       long_mark;
        logic       repeat_fire;
        logic [1:0] tap_or_hold;
    } t_key_stat;

    typedef struct packed {
        t_key up_key;
        t_key down_key;
        t_key left_key;
        t_key right_key;
    } t_dir_cfg;

    typedef struct packed {
        t_count short_hold;
        t_count long_hold;
    } t_hold_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/khet_counter_bank.sv =====
`default_nettype none

// Hold counters and previous-tick copies for all keys, with the query read-out.
module khet_counter_bank import khet_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_go,
    input  wire t_req                i_req,
    input  wire t_hold_cfg           i_hold_cfg,
    output t_key_stat                o_stat,
    output logic [NUM_KEYS-1:0]      o_pressed
);

    t_count r_hold  [NUM_KEYS];
    t_count r_prior [NUM_KEYS];
    t_count n_hold  [NUM_KEYS];
    t_count n_prior [NUM_KEYS];

    logic   in_range;
    t_count cur;
    t_count pri;
    logic   fire;
    logic   do_rewind;
    t_count rewind;

    always_comb begin
        in_range  = {1'b0, i_req.key_index} < (KEY_W + 1)'(NUM_KEYS);
        cur       = in_range ? r_hold[i_req.key_index]  : '0;
        pri       = in_range ? r_prior[i_req.key_index] : '0;
        fire      = 1'b0;
        do_rewind = 1'b0;
        rewind    = cur;

        case (i_req.repeat_mode)
            RPT_NORMAL: begin
                if (cur == COUNT_ONE) begin
                    fire = 1'b1;
                end else if (cur == NORMAL_FIRE) begin
                    fire      = 1'b1;
                    do_rewind = 1'b1;
                    rewind    = NORMAL_BACK;
                end
            end
            RPT_SHORT: begin
                if (cur == COUNT_ONE) begin
                    fire = 1'b1;
                end else if (cur == SHORT_FIRE) begin
                    fire      = 1'b1;
                    do_rewind = 1'b1;
                    rewind    = SHORT_BACK;
                end
            end
            default: begin
            end
        endcase

        o_stat = '0;
        if (i_req.req_type == REQ_QUERY && in_range) begin
            o_stat.hold_count  = cur;
            o_stat.first_press = (cur == COUNT_ONE);
            o_stat.released    = (pri != '0) && (cur == '0);
            o_stat.short_mark  = (cur == i_hold_cfg.short_hold);
            o_stat.long_mark   = (cur == i_hold_cfg.long_hold);
            o_stat.repeat_fire = fire;
            priority if ((pri != '0) && (pri < i_hold_cfg.long_hold) && (cur == '0)) begin
                o_stat.tap_or_hold = TOH_TAP;
            end else if (cur == i_hold_cfg.long_hold) begin
                o_stat.tap_or_hold = TOH_HOLD;
            end else begin
                o_stat.tap_or_hold = TOH_NONE;
            end
        end

        for (int i = 0; i < NUM_KEYS; i++) begin
            n_hold[i]  = r_hold[i];
            n_prior[i] = r_prior[i];
            case (i_req.req_type)
                REQ_TICK: begin
                    n_prior[i] = r_hold[i];
                    if (i_req.key_bits[i]) begin
                        n_hold[i] = (r_hold[i] == COUNT_MAX) ? COUNT_MAX
                                                              : r_hold[i] + COUNT_ONE;
                    end else begin
                        n_hold[i] = '0;
                    end
                end
                REQ_QUERY: begin
                    if (in_range && do_rewind && (KEY_W'(i) == i_req.key_index)) begin
                        n_hold[i] = rewind;
                    end
                end
                REQ_BUMP: begin
                    if (in_range && (KEY_W'(i) == i_req.key_index)) begin
                        n_hold[i] = r_hold[i] + COUNT_ONE;
                    end
                end
                default: begin
                end
            endcase
            o_pressed[i] = (n_hold[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '{default: '0};
            r_prior <= '{default: '0};
        end else if (i_go) begin
            r_hold  <= n_hold;
            r_prior <= n_prior;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/khet_dir_decode.sv =====
`default_nettype none

// Four-way and eight-way direction codes from the pressed state of four keys.
module khet_dir_decode import khet_pkg::*; (
    input  wire logic [NUM_KEYS-1:0] i_pressed,
    input  wire t_dir_cfg            i_dir_cfg,
    output logic [3:0]               o_dir_four,
    output logic [3:0]               o_dir_eight
);

    logic up_on;
    logic down_on;
    logic left_on;
    logic right_on;

    // A direction key past the key count is never pressed.
    always_comb begin
        up_on    = ({1'b0, i_dir_cfg.up_key} < (KEY_W + 1)'(NUM_KEYS))
                   && i_pressed[i_dir_cfg.up_key];
        down_on  = ({1'b0, i_dir_cfg.down_key} < (KEY_W + 1)'(NUM_KEYS))
                   && i_pressed[i_dir_cfg.down_key];
        left_on  = ({1'b0, i_dir_cfg.left_key} < (KEY_W + 1)'(NUM_KEYS))
                   && i_pressed[i_dir_cfg.left_key];
        right_on = ({1'b0, i_dir_cfg.right_key} < (KEY_W + 1)'(NUM_KEYS))
                   && i_pressed[i_dir_cfg.right_key];

        priority if (down_on) begin
            o_dir_four = DIR_DOWN;
        end else if (left_on) begin
            o_dir_four = DIR_LEFT;
        end else if (right_on) begin
            o_dir_four = DIR_RIGHT;
        end else if (up_on) begin
            o_dir_four = DIR_UP;
        end else begin
            o_dir_four = DIR_NONE;
        end

        priority if (left_on && down_on) begin
            o_dir_eight = DIR_DL;
        end else if (down_on && right_on) begin
            o_dir_eight = DIR_DR;
        end else if (left_on && up_on) begin
            o_dir_eight = DIR_UL;
        end else if (right_on && up_on) begin
            o_dir_eight = DIR_UR;
        end else begin
            o_dir_eight = o_dir_four;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/key_hold_event_tracker.sv =====
// An accepted item is held in the input register, and its result is offered from the result register.
// Throughput: one item per cycle unless the output stalls; each item gives exactly one result.
// The whole item is handled in one pass of the per-key counter lanes between the two registers.
// Reset (synchronous, active low) clears all hold and previous counters, empties both
// registers and loads the configuration defaults: up 3, down 12, left 13, right 2, short 7, long 14.
`default_nettype none

module key_hold_event_tracker import khet_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_req                  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_rsp                       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers. They must be written only while no item is in flight (a duty of the user;
    // the block itself does not enforce it), so the counter lanes may read them directly.
    t_dir_cfg  r_dir_cfg;
    t_hold_cfg r_hold_cfg;

    // Input register: holds the accepted item until the result register can take its result.
    logic r_in_valid;
    t_req r_in;

    // Result register: the finished result waits here for its output transfer.
    logic r_out_valid;
    t_rsp r_out;

    logic                advance;
    t_key_stat           key_stat;
    logic [NUM_KEYS-1:0] pressed;
    logic [3:0]          dir_four;
    logic [3:0]          dir_eight;
    t_rsp                n_out;

    // The item in the input register moves on whenever the result register is empty or
    // is handing its result over in this cycle. The counters are updated at that same edge,
    // so the next item always sees the state this item leaves.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_cfg.up_key      <= RST_UP_KEY;
            r_dir_cfg.down_key    <= RST_DOWN_KEY;
            r_dir_cfg.left_key    <= RST_LEFT_KEY;
            r_dir_cfg.right_key   <= RST_RIGHT_KEY;
            r_hold_cfg.short_hold <= RST_SHORT_HOLD;
            r_hold_cfg.long_hold  <= RST_LONG_HOLD;
        end else if (i_cfg_we) begin
            // Key registers keep only their low bits; writes past the list are dropped.
            unique case (i_cfg_index)
                CFG_UP_KEY:     r_dir_cfg.up_key      <= i_cfg_wdata[KEY_W-1:0];
                CFG_DOWN_KEY:   r_dir_cfg.down_key    <= i_cfg_wdata[KEY_W-1:0];
                CFG_LEFT_KEY:   r_dir_cfg.left_key    <= i_cfg_wdata[KEY_W-1:0];
                CFG_RIGHT_KEY:  r_dir_cfg.right_key   <= i_cfg_wdata[KEY_W-1:0];
                CFG_SHORT_HOLD: r_hold_cfg.short_hold <= i_cfg_wdata[CNT_W-1:0];
                CFG_LONG_HOLD:  r_hold_cfg.long_hold  <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // One lane per key: tick, repeat rewind and manual bump all land here.
    khet_counter_bank u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (advance),
        .i_req      (r_in),
        .i_hold_cfg (r_hold_cfg),
        .o_stat     (key_stat),
        .o_pressed  (pressed)
    );

    // Directions look at the counters as this item leaves them.
    khet_dir_decode u_dir (
        .i_pressed   (pressed),
        .i_dir_cfg   (r_dir_cfg),
        .o_dir_four  (dir_four),
        .o_dir_eight (dir_eight)
    );

    always_comb begin
        n_out.hold_count  = key_stat.hold_count;
        n_out.first_press = key_stat.first_press;
        n_out.released    = key_stat.released;
        n_out.short_mark  = key_stat.short_mark;
        n_out.long_mark   = key_stat.long_mark;
        n_out.repeat_fire = key_stat.repeat_fire;
        n_out.tap_or_hold = key_stat.tap_or_hold;
        n_out.dir_four    = dir_four;
        n_out.dir_eight   = dir_eight;
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/khet_checker.sv =====
`default_nettype none

`include "key_hold_event_tracker_defines.svh"

// Port-level checks for the key hold event tracker.
module khet_checker import khet_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp o_out_data
);

    // A stalled result stays offered and unchanged.
    `KHET_ASSERT_NXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result dropped or changed")

    // A release means the counter is zero, so no first press or repeat can be flagged with it.
    `KHET_ASSERT_IMP(a_release_zero, o_out_valid && o_out_data.released, o_out_data.hold_count == '0 && !o_out_data.first_press && !o_out_data.repeat_fire, "release with nonzero count")

    // Auto-repeat only fires on a first press or at a repeat point.
    `KHET_ASSERT_IMP(a_fire_count, o_out_valid && o_out_data.repeat_fire, o_out_data.hold_count == COUNT_ONE || o_out_data.hold_count == NORMAL_FIRE || o_out_data.hold_count == SHORT_FIRE, "repeat fired off a repeat point")

    // With no direction pressed there can be no diagonal either.
    `KHET_ASSERT_IMP(a_dir_agree, o_out_valid && o_out_data.dir_four == DIR_NONE, o_out_data.dir_eight == DIR_NONE, "diagonal without a pressed direction")

endmodule

bind key_hold_event_tracker khet_checker u_khet_checker (.*);

`default_nettype wire
